/* src/lfo_modulated_delay_vibrato_top_macros.svh */
// Assertion helpers for the vibrato block. Both expect clk and rst_n in scope.
`ifndef LFO_MODULATED_DELAY_VIBRATO_TOP_MACROS_SVH
`define LFO_MODULATED_DELAY_VIBRATO_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define VIB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define VIB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define VIB_ASSERT_IMPL(lbl, ante, cons, msg)
`define VIB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* src/lfo_vib_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lfo_vib_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int FRAC_BITS     = 8;
  localparam int IO_CHANNELS   = 2;
  localparam int PHASE_BITS    = 32;
  localparam int STEP_BITS     = 31;
  localparam int DELAY_BITS    = 19;
  localparam int SINE_ENTRIES  = 256;
  localparam int SINE_BITS     = $clog2(SINE_ENTRIES);
  localparam int SINE_ROM_BITS = $clog2(SINE_ENTRIES + 1);
  localparam int SINE_MAG_BITS = 15;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 31;

  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_PHASE_STEP   = 2'd0;
  localparam cfg_idx_t REG_CENTRE_DELAY = 2'd1;
  localparam cfg_idx_t REG_DEPTH_DELAY  = 2'd2;

  localparam logic [STEP_BITS-1:0]  PHASE_STEP_RST   = 31'd447392;
  localparam logic [DELAY_BITS-1:0] CENTRE_DELAY_RST = 19'd61440;
  localparam logic [DELAY_BITS-1:0] DEPTH_DELAY_RST  = 19'd18432;

  // Quarter-wave sine entry, Q30 Taylor series to x^13, rounded to Q15.
  // Only ever called with constant arguments to build the table.
  function automatic logic [SINE_MAG_BITS-1:0] sine_entry(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] usum;
    longint      sum;
    x    = (64'(k) * PI_HALF_Q30) / SINE_ENTRIES;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > (longint'(1) << 30)) begin
      sum = longint'(1) << 30;
    end
    usum = 64'(sum);
    usum = (usum * 64'd32767 + (64'd1 << 29)) >> 30;
    return usum[SINE_MAG_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

/* src/lfo_modulated_delay_vibrato_top.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "lfo_modulated_delay_vibrato_top_macros.svh"

// Sine-LFO vibrato over a fractional delay line, fully wet, two channels.
// A request runs these steps from acceptance to a registered result:
// sine table lookup, depth multiply, delay clamp, read position, then two
// reads through the single read port of each channel's delay memory (the two
// neighbouring taps) and the linear interpolation, after which the new sample
// is written. The next request is taken in the cycle after the result is
// registered, so no new request is taken while one is in flight; a result
// left waiting holds the block in its final step. The delay memories need
// no clearing pass after reset: a fill mark (write index plus a wrapped
// flag) makes never-written taps read as zero. Registers may only be
// written while the block is idle.
module lfo_modulated_delay_vibrato_top
  import lfo_vib_pkg::*;
#(
  parameter int DELAY_LENGTH = 2048,
  parameter int CHANNELS     = 2
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire cfg_idx_t                      cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]      cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_ch0,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_ch1,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0]      out_ch0,
  output logic signed [SAMPLE_BITS-1:0]      out_ch1
);

  localparam int AW  = $clog2(DELAY_LENGTH);
  localparam int PW  = AW + FRAC_BITS;
  localparam int DSW = (PW + 1 > DELAY_BITS + 2) ? PW + 1 : DELAY_BITS + 2;
  localparam int ACW = SAMPLE_BITS + FRAC_BITS + 2;
  localparam int MW  = DELAY_BITS + SINE_MAG_BITS;

  localparam logic [AW-1:0] LAST_IDX = AW'(DELAY_LENGTH - 1);
  localparam logic [PW-1:0] DMAX     = PW'((DELAY_LENGTH - 2) * (1 << FRAC_BITS));
  localparam logic [PW:0]   SPAN     = (PW + 1)'(DELAY_LENGTH * (1 << FRAC_BITS));
  localparam logic [SINE_ROM_BITS-1:0] ROM_TOP = SINE_ROM_BITS'(SINE_ENTRIES);
  localparam logic signed [ACW-1:0] RND = ACW'(1 << (FRAC_BITS - 1));

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DLY,
    S_ADR,
    S_RD0,
    S_RD1,
    S_MIX
  } state_t;

  state_t state_r;

  logic [STEP_BITS-1:0]  phase_step_r;
  logic [DELAY_BITS-1:0] centre_delay_r;
  logic [DELAY_BITS-1:0] depth_delay_r;

  logic [PHASE_BITS-1:0]    phase_r;
  logic [AW-1:0]            wr_idx_r;
  logic                     wrapped_r;
  logic [SINE_MAG_BITS-1:0] sine_mag_r;
  logic                     sine_neg_r;
  logic [DELAY_BITS-1:0]    mag_r;
  logic [PW-1:0]            d_r;
  logic [AW-1:0]            i0_r;
  logic [AW-1:0]            i1_r;
  logic [FRAC_BITS-1:0]     w_r;
  logic                     va_r;
  logic                     vb_r;
  logic                     out_valid_r;

  // Constant quarter-wave table, entries 0 .. SINE_ENTRIES.
  logic [SINE_MAG_BITS-1:0] sine_rom [SINE_ENTRIES + 1];
  for (genvar k = 0; k <= SINE_ENTRIES; k++) begin : g_rom
    assign sine_rom[k] = sine_entry(k);
  end

  logic [SINE_BITS-1:0]     sine_idx;
  logic [SINE_ROM_BITS-1:0] rom_addr;
  logic [MW-1:0]            mag_full;
  logic signed [DSW-1:0]    dsum;
  logic [PW-1:0]            d_nxt;
  logic [PW:0]              pdiff;
  logic [PW:0]              pos;
  logic [AW-1:0]            rd_addr;
  logic                     mem_re;
  logic                     rd_valid;
  logic                     mix_go;
  logic                     in_acc;

  logic signed [SAMPLE_BITS-1:0] in_smp [IO_CHANNELS];
  logic signed [SAMPLE_BITS-1:0] res    [IO_CHANNELS];

  assign in_smp[0] = in_sample_ch0;
  assign in_smp[1] = in_sample_ch1;
  assign out_ch0   = res[0];
  assign out_ch1   = res[1];
  assign out_valid = out_valid_r;
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign mix_go    = (state_r == S_MIX) && (!out_valid_r || out_ready);

  // Odd quadrants run the table backwards.
  always_comb begin
    sine_idx = phase_r[PHASE_BITS-3 -: SINE_BITS];
    if (phase_r[PHASE_BITS-2]) begin
      rom_addr = ROM_TOP - SINE_ROM_BITS'(sine_idx);
    end else begin
      rom_addr = SINE_ROM_BITS'(sine_idx);
    end
  end

  assign mag_full = MW'(depth_delay_r) * MW'(sine_mag_r);

  always_comb begin
    if (sine_neg_r) begin
      dsum = DSW'(centre_delay_r) - DSW'(mag_r);
    end else begin
      dsum = DSW'(centre_delay_r) + DSW'(mag_r);
    end
    priority if (dsum[DSW-1]) begin
      d_nxt = '0;
    end else if (dsum > DSW'(DMAX)) begin
      d_nxt = DMAX;
    end else begin
      d_nxt = dsum[PW-1:0];
    end
  end

  // Read position wraps by one span at most.
  always_comb begin
    pdiff = {1'b0, wr_idx_r, {FRAC_BITS{1'b0}}} - {1'b0, d_r};
    if (pdiff[PW]) begin
      pos = pdiff + SPAN;
    end else begin
      pos = pdiff;
    end
  end

  assign mem_re   = (state_r == S_RD0) || (state_r == S_RD1);
  assign rd_addr  = (state_r == S_RD0) ? i0_r : i1_r;
  assign rd_valid = wrapped_r || (rd_addr < wr_idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r   <= PHASE_STEP_RST;
      centre_delay_r <= CENTRE_DELAY_RST;
      depth_delay_r  <= DEPTH_DELAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PHASE_STEP:   phase_step_r   <= cfg_wdata[STEP_BITS-1:0];
        REG_CENTRE_DELAY: centre_delay_r <= cfg_wdata[DELAY_BITS-1:0];
        REG_DEPTH_DELAY:  depth_delay_r  <= cfg_wdata[DELAY_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= '0;
      wr_idx_r    <= '0;
      wrapped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (mix_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            sine_mag_r <= sine_rom[rom_addr];
            sine_neg_r <= phase_r[PHASE_BITS-1];
            state_r    <= S_MUL;
          end
        end
        S_MUL: begin
          mag_r   <= mag_full[MW-1 -: DELAY_BITS];
          state_r <= S_DLY;
        end
        S_DLY: begin
          d_r     <= d_nxt;
          state_r <= S_ADR;
        end
        S_ADR: begin
          i0_r    <= pos[PW-1:FRAC_BITS];
          w_r     <= pos[FRAC_BITS-1:0];
          state_r <= S_RD0;
        end
        S_RD0: begin
          va_r    <= rd_valid;
          i1_r    <= (i0_r == LAST_IDX) ? '0 : i0_r + 1'b1;
          state_r <= S_RD1;
        end
        S_RD1: begin
          vb_r    <= rd_valid;
          state_r <= S_MIX;
        end
        S_MIX: begin
          if (mix_go) begin
            phase_r     <= phase_r + PHASE_BITS'(phase_step_r);
            if (wr_idx_r == LAST_IDX) begin
              wr_idx_r  <= '0;
              wrapped_r <= 1'b1;
            end else begin
              wr_idx_r <= wr_idx_r + 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  for (genvar ch = 0; ch < IO_CHANNELS; ch++) begin : g_ch
    if (ch < CHANNELS) begin : g_on
      logic [SAMPLE_BITS-1:0]        mem [DELAY_LENGTH];
      logic signed [SAMPLE_BITS-1:0] rd_q;
      logic signed [SAMPLE_BITS-1:0] a_r;
      logic signed [SAMPLE_BITS-1:0] smp_r;
      logic signed [SAMPLE_BITS-1:0] res_r;
      logic signed [SAMPLE_BITS-1:0] a_v;
      logic signed [SAMPLE_BITS-1:0] b_v;
      logic signed [SAMPLE_BITS:0]   dif;
      logic signed [ACW-1:0]         acc;

      always_ff @(posedge clk) begin
        if (mix_go) begin
          mem[wr_idx_r] <= smp_r;
        end
        if (mem_re) begin
          rd_q <= mem[rd_addr];
        end
      end

      // a*(256-w) + b*w folded to one product: a*256 + (b-a)*w.
      always_comb begin
        a_v = va_r ? a_r : '0;
        b_v = vb_r ? rd_q : '0;
        dif = (SAMPLE_BITS + 1)'(b_v) - (SAMPLE_BITS + 1)'(a_v);
        acc = (ACW'(a_v) <<< FRAC_BITS) + ACW'(dif) * ACW'($signed({1'b0, w_r})) + RND;
      end

      always_ff @(posedge clk) begin
        if (in_acc) begin
          smp_r <= in_smp[ch];
        end
        if (state_r == S_RD1) begin
          a_r <= rd_q;
        end
        if (mix_go) begin
          res_r <= acc[FRAC_BITS +: SAMPLE_BITS];
        end
      end

      assign res[ch] = res_r;
    end else begin : g_off
      assign res[ch] = '0;
    end
  end

  `VIB_ASSERT_NEXT(a_idx_hold, state_r != S_MIX, $stable(wr_idx_r) && $stable(phase_r), "write index or phase moved outside the mix step")
  `VIB_ASSERT_IMPL(a_res_src, $rose(out_valid_r), $past(state_r) == S_MIX, "result raised outside the mix step")
  `VIB_ASSERT_IMPL(a_tap_range, state_r == S_RD0, (i0_r <= LAST_IDX) && (d_r <= DMAX), "tap address or delay out of range")

endmodule

`default_nettype wire

/* tb/lfo_vib_checker.sv */
`timescale 1ns / 1ps

module lfo_vib_checker
  import lfo_vib_pkg::*;
#(
  parameter int DELAY_LENGTH = 2048
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  cfg_idx_t                      cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_wdata,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_ch0,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_ch1,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [SAMPLE_BITS-1:0] out_ch0,
  input  logic signed [SAMPLE_BITS-1:0] out_ch1,
  output int                            mismatches,
  output int                            frames_waiting,
  output int                            frames_checked
);

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] ch0;
    logic signed [SAMPLE_BITS-1:0] ch1;
  } wet_frame_t;

  localparam longint LINE_SPAN = longint'(DELAY_LENGTH) << FRAC_BITS;
  localparam longint DELAY_CEIL = longint'(DELAY_LENGTH - 2) << FRAC_BITS;

  logic [SINE_MAG_BITS-1:0]      quarter_sine [0:SINE_ENTRIES];
  logic signed [SAMPLE_BITS-1:0] line_ch0 [DELAY_LENGTH];
  logic signed [SAMPLE_BITS-1:0] line_ch1 [DELAY_LENGTH];
  logic [STEP_BITS-1:0]          rate_r;
  logic [DELAY_BITS-1:0]         centre_r;
  logic [DELAY_BITS-1:0]         depth_r;
  logic [PHASE_BITS-1:0]         lfo_angle;
  int                            head;
  wet_frame_t                    wet_frames [$];

  // Q30 Taylor series up to x^13, rounded half up to Q15
  function automatic int taylor_sine(int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] mag;
    longint      acc;
    x    = (64'(k) * PI_HALF_Q30) / 64'(SINE_ENTRIES);
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int n = 1; n <= 6; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > (longint'(1) << 30)) acc = longint'(1) << 30;
    mag = 64'(acc);
    mag = (mag * 64'd32767 + (64'd1 << 29)) >> 30;
    return int'(mag);
  endfunction

  initial begin
    for (int k = 0; k <= SINE_ENTRIES; k++) quarter_sine[k] = SINE_MAG_BITS'(taylor_sine(k));
  end

  function automatic int lfo_value(logic [PHASE_BITS-1:0] ang);
    int unsigned idx;
    int          v;
    idx = int'((64'(ang[29:0]) * 64'(SINE_ENTRIES)) >> 30);
    v = ang[30] ? int'(quarter_sine[SINE_ENTRIES - idx]) : int'(quarter_sine[idx]);
    return ang[31] ? -v : v;
  endfunction

  task automatic run_vibrato(input logic signed [SAMPLE_BITS-1:0] x0,
                             input logic signed [SAMPLE_BITS-1:0] x1);
    int         s;
    longint     swing;
    longint     d;
    longint     pos;
    int         i0;
    int         i1;
    int         w;
    longint     acc0;
    longint     acc1;
    wet_frame_t f;
    s = lfo_value(lfo_angle);
    swing = (longint'(depth_r) * longint'(s < 0 ? -s : s)) >>> 15;
    d = (s < 0) ? longint'(centre_r) - swing : longint'(centre_r) + swing;
    if (d < 0) d = 0;
    if (d > DELAY_CEIL) d = DELAY_CEIL;
    pos = ((longint'(head) << FRAC_BITS) + LINE_SPAN - d) % LINE_SPAN;
    i0 = int'(pos >>> FRAC_BITS);
    i1 = (i0 + 1) % DELAY_LENGTH;
    w = int'(pos % 256);
    acc0 = longint'(line_ch0[i0]) * longint'(256 - w) + longint'(line_ch0[i1]) * longint'(w);
    acc1 = longint'(line_ch1[i0]) * longint'(256 - w) + longint'(line_ch1[i1]) * longint'(w);
    // floor of (acc + half) / 256, i.e. round half up
    f.ch0 = SAMPLE_BITS'((acc0 + 128) >>> FRAC_BITS);
    f.ch1 = SAMPLE_BITS'((acc1 + 128) >>> FRAC_BITS);
    wet_frames.push_back(f);
    // taps are read before the new sample lands
    line_ch0[head] = x0;
    line_ch1[head] = x1;
    head = (head + 1) % DELAY_LENGTH;
    lfo_angle = lfo_angle + PHASE_BITS'(rate_r);
  endtask

  task automatic log_fault(input string msg);
    if (mismatches < 10) $display("%0t ns checker: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    wet_frame_t want;
    if (!rst_n) begin
      for (int i = 0; i < DELAY_LENGTH; i++) begin
        line_ch0[i] = '0;
        line_ch1[i] = '0;
      end
      head = 0;
      lfo_angle = '0;
      rate_r = PHASE_STEP_RST;
      centre_r = CENTRE_DELAY_RST;
      depth_r = DEPTH_DELAY_RST;
      wet_frames.delete();
      mismatches = 0;
      frames_checked = 0;
      frames_waiting <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PHASE_STEP:   rate_r = cfg_wdata[STEP_BITS-1:0];
          REG_CENTRE_DELAY: centre_r = cfg_wdata[DELAY_BITS-1:0];
          REG_DEPTH_DELAY:  depth_r = cfg_wdata[DELAY_BITS-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (wet_frames.size() == 0) begin
          log_fault($sformatf("result %0d/%0d with no request outstanding", out_ch0, out_ch1));
        end else begin
          want = wet_frames.pop_front();
          if (out_ch0 !== want.ch0)
            log_fault($sformatf("frame %0d out_ch0 expected %0d got %0d",
                                frames_checked, want.ch0, out_ch0));
          if (out_ch1 !== want.ch1)
            log_fault($sformatf("frame %0d out_ch1 expected %0d got %0d",
                                frames_checked, want.ch1, out_ch1));
        end
        frames_checked++;
      end
      if (in_valid && in_ready) run_vibrato(in_sample_ch0, in_sample_ch1);
      frames_waiting <= wet_frames.size();
    end
  end

endmodule

/* tb/tb_lfo_modulated_delay_vibrato_top.sv */
`timescale 1ns / 1ps

module tb_lfo_modulated_delay_vibrato_top;
  import lfo_vib_pkg::*;

  localparam cfg_idx_t                REG_SPARE    = 2'd3;  // not decoded by the block
  localparam logic [STEP_BITS-1:0]  STEP_QUARTER = 31'h4000_0000;
  localparam logic [DELAY_BITS-1:0] DELAY_TOP    = 19'd523776;
  localparam int PHASES         = 10;
  localparam int FRAMES_PER_PH  = 188;
  localparam int HOLD_CYCLES    = 80;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  cfg_idx_t                      cfg_index = REG_PHASE_STEP;
  logic [CFG_DATA_BITS-1:0]      cfg_wdata = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] in_sample_ch0 = '0;
  logic signed [SAMPLE_BITS-1:0] in_sample_ch1 = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_ch0;
  logic signed [SAMPLE_BITS-1:0] out_ch1;

  int mismatches;
  int frames_waiting;
  int frames_checked;
  int frames_sent = 0;
  bit idle_on = 1'b0;
  int hold_asked = 0;

  logic signed [SAMPLE_BITS-1:0] corner [8] = '{16'sh7FFF, -16'sh8000, 16'sh0000, -16'sh0001,
                                               16'sh5555, 16'shAAAA, 16'sh0001, 16'sh7FFE};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  lfo_modulated_delay_vibrato_top dut (.*);

  lfo_vib_checker checker_i (.*);

  function automatic logic signed [SAMPLE_BITS-1:0] audio_word();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return -16'sh8000;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [DELAY_BITS-1:0] pick_delay(int reach);
    case ($urandom_range(0, 6))
      0: return '0;
      1: return DELAY_TOP;
      2: return '1;
      default: return DELAY_BITS'($urandom_range(0, reach << FRAC_BITS));
    endcase
  endfunction

  task automatic send_frame(input logic signed [SAMPLE_BITS-1:0] a,
                            input logic signed [SAMPLE_BITS-1:0] b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_ch0 <= a;
    in_sample_ch1 <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    frames_sent++;
  endtask

  // stop offering and wait for every outstanding request to come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frames_waiting != 0) @(posedge clk);
  endtask

  // upper bits of the delay registers carry junk, which the block must drop
  task automatic set_config(input logic [STEP_BITS-1:0] rate,
                            input logic [DELAY_BITS-1:0] centre,
                            input logic [DELAY_BITS-1:0] depth);
    logic [CFG_DATA_BITS-1:0] word;
    cfg_we <= 1'b1;
    cfg_index <= REG_PHASE_STEP;
    cfg_wdata <= rate;
    @(posedge clk);
    word = CFG_DATA_BITS'($urandom);
    word[DELAY_BITS-1:0] = centre;
    cfg_index <= REG_CENTRE_DELAY;
    cfg_wdata <= word;
    @(posedge clk);
    word = CFG_DATA_BITS'($urandom);
    word[DELAY_BITS-1:0] = depth;
    cfg_index <= REG_DEPTH_DELAY;
    cfg_wdata <= word;
    @(posedge clk);
    cfg_index <= REG_SPARE;
    cfg_wdata <= CFG_DATA_BITS'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int hold_served;
    hold_served = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_asked != hold_served) begin
        hold_served = hold_asked;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    logic [STEP_BITS-1:0]  rate;
    logic [DELAY_BITS-1:0] centre;
    logic [DELAY_BITS-1:0] depth;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    idle_on = 1'b1;

    // reset settings, sample extremes
    for (int i = 0; i < 8; i++) send_frame(corner[i], corner[7 - i]);

    // quarter-turn steps walk all LFO quadrants; full depth clamps both ends
    settle();
    set_config(STEP_QUARTER, 19'd1024, DELAY_TOP);
    for (int i = 0; i < 8; i++) send_frame(corner[7 - i], corner[i]);

    // zero delay: taps sit on the slot about to be overwritten
    settle();
    set_config('0, '0, '0);
    for (int i = 0; i < 4; i++) send_frame(corner[2 * i], corner[2 * i + 1]);

    // 1.5 samples: interpolation weight of one half, rounding half up
    settle();
    set_config('0, 19'h180, '0);
    send_frame(16'sh0001, -16'sh0001);
    send_frame(16'sh0000, 16'sh0000);
    send_frame(-16'sh0001, 16'sh0001);
    send_frame(16'sh7FFF, -16'sh8000);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case ($urandom_range(0, 4))
        0: rate = '0;
        1: rate = STEP_QUARTER;
        2: rate = STEP_BITS'($urandom_range(1, 1 << 20));
        3: rate = STEP_BITS'($urandom_range(0, 1 << 30));
        default: rate = STEP_BITS'($urandom);
      endcase
      centre = pick_delay(400);
      depth = pick_delay(200);
      if (ph == PHASES - 2) begin
        rate = '1;
        centre = '1;
        depth = '1;
      end
      if (ph == PHASES - 1) begin
        centre = '0;
        depth = '0;
      end
      set_config(rate, centre, depth);
      idle_on = (ph % 3 != 2) && (ph != PHASES - 1);
      for (int n = 0; n < FRAMES_PER_PH; n++) begin
        if (ph == 3 && n == 30) hold_asked++;
        if (ph == 6 && n == 100) settle();
        send_frame(audio_word(), audio_word());
      end
    end

    settle();
    repeat (16) @(posedge clk);
    $display("%0d frames sent, %0d results compared, %0d mismatches",
             frames_sent, frames_checked, mismatches);
    $display("covered LFO quadrants, delay clamps, zero and half-sample delays, line wrap, stalls");
    if (mismatches == 0 && frames_waiting == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timed out with %0d results outstanding", frames_waiting);
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/lfo_vib_pkg.sv
src/lfo_modulated_delay_vibrato_top.sv
tb/lfo_vib_checker.sv
tb/tb_lfo_modulated_delay_vibrato_top.sv
